/* design/wpsfe_pkg.sv */
package wpsfe_pkg;

	// result kinds (m_tuser)
	localparam logic [1:0] RK_SAMPLE = 2'd0;
	localparam logic [1:0] RK_ACCEPT = 2'd1;
	localparam logic [1:0] RK_REJECT = 2'd2;
	localparam logic [1:0] RK_END    = 2'd3;

	// header error codes
	localparam logic [3:0] ERR_NOT_RIFF = 4'd0;
	localparam logic [3:0] ERR_NOT_WAVE = 4'd1;
	localparam logic [3:0] ERR_NO_FMT   = 4'd2;
	localparam logic [3:0] ERR_NO_DATA  = 4'd3;
	localparam logic [3:0] ERR_NOT_PCM  = 4'd4;
	localparam logic [3:0] ERR_FMT_SIZE = 4'd5;
	localparam logic [3:0] ERR_CHANNELS = 4'd6;
	localparam logic [3:0] ERR_RATE     = 4'd7;
	localparam logic [3:0] ERR_DEPTH    = 4'd8;

	// configuration register indexes
	localparam logic [1:0] REG_CHANNELS = 2'd0;
	localparam logic [1:0] REG_RATE     = 2'd1;
	localparam logic [1:0] REG_GAIN     = 2'd2;

	localparam logic [1:0]  CHANNELS_RST = 2'd2;
	localparam logic [31:0] RATE_RST     = 32'd44100;
	localparam logic [16:0] GAIN_RST     = 17'd65536;

	// header byte positions
	localparam logic [5:0] HDR_LAST = 6'd43;
	localparam logic [5:0] TAG_POS  = 6'd36;

	// expected header bytes as little-endian words, byte i at bits 8*i
	localparam logic [31:0] W_RIFF  = 32'h4646_4952;
	localparam logic [31:0] W_WAVE  = 32'h4556_4157;
	localparam logic [31:0] W_FMT   = 32'h0074_6D66;
	localparam logic [31:0] W_FSIZE = 32'h0000_0010;
	localparam logic [31:0] W_PCM   = 32'h0000_0001;
	localparam logic [31:0] W_DEPTH = 32'h0010_0000;
	localparam logic [31:0] W_DATA  = 32'h6174_6164;
	localparam logic [31:0] W_LIST  = 32'h5453_494C;

	typedef struct packed {
		logic [1:0]  chans;
		logic [31:0] rate;
		logic [16:0] gain;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] sample;
		logic               ch;
		logic [3:0]         err;
	} res_t;

	typedef struct packed {
		logic [1:0]      cnt;
		res_t [2:0]      res;
	} bundle_t;

	function automatic logic byte_is(logic [31:0] w, logic [1:0] idx, logic [7:0] b);
		return b == w[{idx, 3'b000} +: 8];
	endfunction

endpackage

/* design/wpsfe_scale.sv */
module wpsfe_scale (
	input  logic signed [15:0] sample_in,
	input  logic [16:0]        gain,
	output logic signed [15:0] sample_out
);
	logic signed [17:0] g;
	logic signed [33:0] prod;
	logic signed [17:0] q;

	assign g    = signed'({1'b0, gain});
	assign prod = sample_in * g;
	// arithmetic shift: floor division by 65536
	assign q    = prod[33:16];

	always_comb begin
		if (q > 18'sd32767) begin
			sample_out = 16'sh7FFF;
		end else if (q < -18'sd32768) begin
			sample_out = 16'sh8000;
		end else begin
			sample_out = q[15:0];
		end
	end
endmodule

/* design/wpsfe_parse.sv */
module wpsfe_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               in_kind,
	input  logic [7:0]         in_byte,
	input  wpsfe_pkg::cfg_t    cfg,
	output wpsfe_pkg::bundle_t bnd
);
	import wpsfe_pkg::*;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_SKIP    = 5'b00010,
		PH_SECTION = 5'b00100,
		PH_DATA    = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [5:0]  pos_q, pos_d;
	logic        par_q, par_d;
	logic        fch_q, fch_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] rem_q, rem_d;

	logic [7:0]         low_q;
	logic signed [15:0] left_q;
	logic               riff_q, wave_q, fmt_q, fsize_q, pcm_q, depth_q, tdata_q, tlist_q;
	logic [15:0]        chan_q;
	logic [31:0]        rate_q;
	logic [23:0]        size_q;

	logic               hdr_wr;
	logic               dat_wr;
	logic signed [15:0] scaled;
	logic [31:0]        size_full;
	logic               chan_ok;

	wpsfe_scale u_scale (
		.sample_in  (signed'({in_byte, low_q})),
		.gain       (cfg.gain),
		.sample_out (scaled)
	);

	assign hdr_wr    = take && !in_kind && (phase_q == PH_HEADER || phase_q == PH_SECTION);
	assign dat_wr    = take && !in_kind && (phase_q == PH_DATA);
	assign size_full = {in_byte, size_q};
	assign chan_ok   = (cfg.chans == 2'd1 || cfg.chans == 2'd2) && chan_q == {14'd0, cfg.chans};

	// capture header fields as they stream past
	always_ff @(posedge clk) begin
		if (hdr_wr) begin
			if (pos_q inside {[6'd0:6'd3]})
				riff_q <= (pos_q[1:0] == 2'd0 || riff_q) && byte_is(W_RIFF, pos_q[1:0], in_byte);
			if (pos_q inside {[6'd8:6'd11]})
				wave_q <= (pos_q[1:0] == 2'd0 || wave_q) && byte_is(W_WAVE, pos_q[1:0], in_byte);
			if (pos_q inside {[6'd12:6'd14]})
				fmt_q <= (pos_q[1:0] == 2'd0 || fmt_q) && byte_is(W_FMT, pos_q[1:0], in_byte);
			if (pos_q inside {[6'd16:6'd19]})
				fsize_q <= (pos_q[1:0] == 2'd0 || fsize_q)
					&& byte_is(W_FSIZE, pos_q[1:0], in_byte);
			if (pos_q inside {[6'd20:6'd21]})
				pcm_q <= (pos_q[1:0] == 2'd0 || pcm_q) && byte_is(W_PCM, pos_q[1:0], in_byte);
			if (pos_q == 6'd22)
				chan_q[7:0] <= in_byte;
			if (pos_q == 6'd23)
				chan_q[15:8] <= in_byte;
			if (pos_q inside {[6'd24:6'd27]})
				rate_q[{pos_q[1:0], 3'b000} +: 8] <= in_byte;
			if (pos_q inside {[6'd34:6'd35]})
				depth_q <= (pos_q == 6'd34 || depth_q) && byte_is(W_DEPTH, pos_q[1:0], in_byte);
			if (pos_q inside {[6'd36:6'd39]}) begin
				tdata_q <= (pos_q[1:0] == 2'd0 || tdata_q)
					&& byte_is(W_DATA, pos_q[1:0], in_byte);
				tlist_q <= (pos_q[1:0] == 2'd0 || tlist_q)
					&& byte_is(W_LIST, pos_q[1:0], in_byte);
			end
			if (pos_q inside {[6'd40:6'd42]})
				size_q[{pos_q[1:0], 3'b000} +: 8] <= in_byte;
		end
	end

	// sample assembly holds
	always_ff @(posedge clk) begin
		if (dat_wr) begin
			if (!par_q) begin
				low_q <= in_byte;
			end else if (cfg.chans == 2'd2 && !fch_q) begin
				left_q <= scaled;
			end
		end
	end

	always_comb begin
		logic [1:0] n;
		logic       do_final;
		n        = 2'd0;
		do_final = 1'b0;
		phase_d  = phase_q;
		pos_d    = pos_q;
		par_d    = par_q;
		fch_d    = fch_q;
		skip_d   = skip_q;
		rem_d    = rem_q;
		bnd      = '0;
		if (in_kind) begin
			phase_d = PH_HEADER;
			pos_d   = 6'd0;
			par_d   = 1'b0;
			fch_d   = 1'b0;
			skip_d  = 32'd0;
			rem_d   = 32'd0;
		end else begin
			case (phase_q)
				PH_HEADER, PH_SECTION: begin
					pos_d = pos_q + 6'd1;
					if (pos_q == HDR_LAST) begin
						if (phase_q == PH_SECTION) begin
							do_final = 1'b1;
						end else if (!riff_q) begin
							phase_d    = PH_DONE;
							bnd.cnt    = 2'd1;
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_NOT_RIFF};
						end else if (!wave_q) begin
							phase_d    = PH_DONE;
							bnd.cnt    = 2'd1;
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_NOT_WAVE};
						end else if (!fmt_q) begin
							phase_d    = PH_DONE;
							bnd.cnt    = 2'd1;
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_NO_FMT};
						end else if (!tdata_q && tlist_q) begin
							// skip the LIST body, then reread the chunk header
							skip_d  = size_full;
							pos_d   = TAG_POS;
							phase_d = (size_full == 32'd0) ? PH_SECTION : PH_SKIP;
						end else begin
							do_final = 1'b1;
						end
					end
					if (do_final) begin
						bnd.cnt = 2'd1;
						phase_d = PH_DONE;
						if (!tdata_q) begin
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_NO_DATA};
						end else if (!pcm_q) begin
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_NOT_PCM};
						end else if (!fsize_q) begin
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_FMT_SIZE};
						end else if (!chan_ok) begin
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_CHANNELS};
						end else if (rate_q != cfg.rate) begin
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_RATE};
						end else if (!depth_q) begin
							bnd.res[0] = '{kind: RK_REJECT, sample: '0, ch: 1'b0, err: ERR_DEPTH};
						end else begin
							bnd.res[0] = '{kind: RK_ACCEPT, sample: '0, ch: 1'b0, err: '0};
							rem_d   = size_full;
							pos_d   = 6'd0;
							par_d   = 1'b0;
							fch_d   = 1'b0;
							phase_d = PH_DATA;
							if (size_full == 32'd0) begin
								bnd.cnt    = 2'd2;
								bnd.res[1] = '{kind: RK_END, sample: '0, ch: 1'b0, err: '0};
								phase_d    = PH_DONE;
							end
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_q - 32'd1;
					if (skip_q == 32'd1)
						phase_d = PH_SECTION;
				end
				PH_DATA: begin
					par_d = !par_q;
					rem_d = rem_q - 32'd1;
					if (par_q) begin
						if (cfg.chans == 2'd2) begin
							if (!fch_q) begin
								fch_d = 1'b1;
							end else begin
								bnd.res[0] = '{kind: RK_SAMPLE, sample: left_q, ch: 1'b0, err: '0};
								bnd.res[1] = '{kind: RK_SAMPLE, sample: scaled, ch: 1'b1, err: '0};
								n     = 2'd2;
								fch_d = 1'b0;
							end
						end else begin
							bnd.res[0] = '{kind: RK_SAMPLE, sample: scaled, ch: 1'b0, err: '0};
							n     = 2'd1;
							fch_d = 1'b0;
						end
					end
					if (rem_q == 32'd1) begin
						bnd.res[n] = '{kind: RK_END, sample: '0, ch: 1'b0, err: '0};
						n       = n + 2'd1;
						phase_d = PH_DONE;
					end
					bnd.cnt = n;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 6'd0;
			par_q   <= 1'b0;
			fch_q   <= 1'b0;
			skip_q  <= 32'd0;
			rem_q   <= 32'd0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			par_q   <= par_d;
			fch_q   <= fch_d;
			skip_q  <= skip_d;
			rem_q   <= rem_d;
		end
	end
endmodule

/* design/wpsfe_outq.sv */
module wpsfe_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  wpsfe_pkg::bundle_t bnd,
	output logic               room,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [15:0] sample_value, [16] channel_index,
	                                      // [20:17] error_code, [23:21] zero
	output logic [1:0]         m_tuser,   // [1:0] result_kind
	output logic               m_tlast
);
	import wpsfe_pkg::*;

	res_t [2:0] slot_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tlast  = cnt_q == 2'd1;
	assign room     = cnt_q == 2'd0 || (cnt_q == 2'd1 && m_tready);
	assign m_tdata  = {3'd0, slot_q[0].err, slot_q[0].ch, slot_q[0].sample};
	assign m_tuser  = slot_q[0].kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bnd.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// advance the result slots toward the port
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= bnd.res;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end
endmodule

/* design/wav_pcm_stream_front_end.sv */
// A byte accepted into the input register is parsed into results for the result buffer.
// Throughput: one byte per cycle while the buffer has room; results leave one per cycle
// while m_tready is high, from a three-entry buffer; a byte with two or three results holds
// the input until its last result leaves. The multiply and clamp sit in the single parse stage.
// Reset: arst_n clears the parser, the result buffer and the input register, and loads
// the configuration defaults (2 channels, 44100 Hz, unity gain); no clearing pass.
module wav_pcm_stream_front_end (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic [0:0]  s_tuser,    // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [15:0] sample_value, [16] channel_index,
	                                // [20:17] error_code, [23:21] zero
	output logic [1:0]  m_tuser,    // [1:0] result_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import wpsfe_pkg::*;

	cfg_t    cfg_q;
	logic    in_vld_s1;
	logic    in_kind_s1;
	logic [7:0] in_byte_s1;
	logic    room;
	logic    take;
	bundle_t bnd;

	assign cfg_ready = 1'b1;
	assign take      = in_vld_s1 && room;
	assign s_tready  = !in_vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chans <= CHANNELS_RST;
			cfg_q.rate  <= RATE_RST;
			cfg_q.gain  <= GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHANNELS: cfg_q.chans <= cfg_data[1:0];
				REG_RATE:     cfg_q.rate  <= cfg_data;
				REG_GAIN:     cfg_q.gain  <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	// hold the request until the parse stage takes it
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_kind_s1 <= s_tuser[0];
			in_byte_s1 <= s_tdata;
		end
	end

	wpsfe_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_kind (in_kind_s1),
		.in_byte (in_byte_s1),
		.cfg     (cfg_q),
		.bnd     (bnd)
	);

	wpsfe_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && bnd.cnt != 2'd0),
		.bnd      (bnd),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);
endmodule

/* design/wpsfe_check.sv */
module wpsfe_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import wpsfe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	a_sample_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != RK_SAMPLE |-> m_tdata[16:0] == 17'd0 && m_tdata[23:21] == 3'd0)
		else $error("sample or channel set on a non-sample result");

	a_err_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != RK_REJECT |-> m_tdata[20:17] == 4'd0)
		else $error("error code set on a result that is no rejection");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RK_END || m_tuser == RK_REJECT) |-> m_tlast)
		else $error("end or rejection not marked last");
endmodule

bind wav_pcm_stream_front_end wpsfe_check u_wpsfe_check (.*);

/* tb/wav_front_checker.sv */
`timescale 1ns / 100ps

module wav_front_checker
	import wpsfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          results_seen
);

	localparam int HDR_BYTES = HDR_LAST + 1;

	typedef enum logic [2:0] {P_HEADER, P_SKIP, P_SECTION, P_DATA, P_DONE} parse_t;

	typedef struct packed {
		res_t r;
		logic last;
	} outcome_t;

	cfg_t               regs;
	parse_t             phase;
	logic [31:0]        pos;
	logic [31:0]        skip_left;
	logic [31:0]        data_left;
	logic [7:0]         hdr [HDR_BYTES];
	logic [7:0]         low_hold;
	logic signed [15:0] left_hold;
	logic               frame_ch;

	outcome_t awaited [$];
	res_t     step_res [3];
	int       step_n;

	function automatic logic [31:0] hdr_word(int p);
		return {hdr[p + 3], hdr[p + 2], hdr[p + 1], hdr[p]};
	endfunction

	function automatic logic [15:0] hdr_half(int p);
		return {hdr[p + 1], hdr[p]};
	endfunction

	function automatic void post(logic [1:0] k, logic signed [15:0] s, logic c, logic [3:0] e);
		res_t x;
		x.kind = k;
		x.sample = s;
		x.ch = c;
		x.err = e;
		step_res[step_n] = x;
		step_n++;
	endfunction

	function automatic void refuse(logic [3:0] e);
		phase = P_DONE;
		post(RK_REJECT, 16'sd0, 1'b0, e);
	endfunction

	function automatic void restart_parser();
		phase = P_HEADER;
		pos = '0;
		skip_left = '0;
		data_left = '0;
		low_hold = '0;
		left_hold = '0;
		frame_ch = 1'b0;
		for (int i = 0; i < HDR_BYTES; i++)
			hdr[i] = '0;
	endfunction

	// floor of product / 65536, then saturate
	function automatic logic signed [15:0] apply_gain(logic signed [15:0] v);
		longint prod;
		longint g;
		prod = longint'(v);
		g = longint'(regs.gain);
		prod = (prod * g) >>> 16;
		if (prod > 32767)
			prod = 32767;
		else if (prod < -32768)
			prod = -32768;
		return prod[15:0];
	endfunction

	// checks that follow the data tag, whether or not a LIST chunk came first
	function automatic void close_header();
		if (hdr_word(TAG_POS) != W_DATA)
			refuse(ERR_NO_DATA);
		else if (hdr_half(20) != W_PCM[15:0])
			refuse(ERR_NOT_PCM);
		else if (hdr_word(16) != W_FSIZE)
			refuse(ERR_FMT_SIZE);
		else if (regs.chans < 1 || regs.chans > 2 || hdr_half(22) != regs.chans)
			refuse(ERR_CHANNELS);
		else if (hdr_word(24) != regs.rate)
			refuse(ERR_RATE);
		else if (hdr_half(34) != W_DEPTH[31:16])
			refuse(ERR_DEPTH);
		else begin
			data_left = hdr_word(40);
			pos = '0;
			frame_ch = 1'b0;
			low_hold = '0;
			phase = P_DATA;
			post(RK_ACCEPT, 16'sd0, 1'b0, ERR_NOT_RIFF);
			if (data_left == 0) begin
				phase = P_DONE;
				post(RK_END, 16'sd0, 1'b0, ERR_NOT_RIFF);
			end
		end
	endfunction

	function automatic void header_complete();
		if (hdr_word(0) != W_RIFF)
			refuse(ERR_NOT_RIFF);
		else if (hdr_word(8) != W_WAVE)
			refuse(ERR_NOT_WAVE);
		else if ((hdr_word(12) & 32'h00FF_FFFF) != W_FMT)
			refuse(ERR_NO_FMT);
		else if (hdr_word(TAG_POS) == W_LIST) begin
			// skip the chunk body, then read a fresh tag and size over bytes 36..43
			skip_left = hdr_word(40);
			pos = 32'(TAG_POS);
			phase = (skip_left == 0) ? P_SECTION : P_SKIP;
		end else
			close_header();
	endfunction

	function automatic void data_step(logic [7:0] b);
		logic signed [15:0] s;
		if (!pos[0])
			low_hold = b;
		else begin
			s = apply_gain({b, low_hold});
			if (regs.chans == 2) begin
				if (!frame_ch) begin
					left_hold = s;
					frame_ch = 1'b1;
				end else begin
					post(RK_SAMPLE, left_hold, 1'b0, ERR_NOT_RIFF);
					post(RK_SAMPLE, s, 1'b1, ERR_NOT_RIFF);
					frame_ch = 1'b0;
				end
			end else begin
				frame_ch = 1'b0;
				post(RK_SAMPLE, s, 1'b0, ERR_NOT_RIFF);
			end
		end
		pos++;
		data_left--;
		if (data_left == 0) begin
			phase = P_DONE;
			post(RK_END, 16'sd0, 1'b0, ERR_NOT_RIFF);
		end
	endfunction

	function automatic void take_byte(logic kind, logic [7:0] b);
		outcome_t o;
		step_n = 0;
		if (kind)
			restart_parser();
		else begin
			case (phase)
				P_HEADER, P_SECTION: begin
					if (pos < HDR_BYTES)
						hdr[pos] = b;
					pos++;
					if (pos >= HDR_BYTES) begin
						if (phase == P_HEADER)
							header_complete();
						else
							close_header();
					end
				end
				P_SKIP: begin
					skip_left--;
					if (skip_left == 0)
						phase = P_SECTION;
				end
				P_DATA: data_step(b);
				default: ;
			endcase
		end
		for (int i = 0; i < step_n; i++) begin
			o.r = step_res[i];
			o.last = (i == step_n - 1);
			awaited.push_back(o);
		end
	endfunction

	function automatic void check_result();
		res_t     got;
		outcome_t want;
		got.kind = m_tuser;
		got.sample = m_tdata[15:0];
		got.ch = m_tdata[16];
		got.err = m_tdata[20:17];
		results_seen++;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t unexpected result: kind %0d sample %0d ch %0d err %0d last %0b",
					$time, got.kind, got.sample, got.ch, got.err, m_tlast);
		end else begin
			want = awaited.pop_front();
			if (want.r.kind !== got.kind || want.r.sample !== got.sample ||
					want.r.ch !== got.ch || want.r.err !== got.err || want.last !== m_tlast) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t mismatch: want kind %0d sample %0d ch %0d err %0d last %0b,",
						$time, want.r.kind, want.r.sample, want.r.ch, want.r.err, want.last);
					$display("    got kind %0d sample %0d ch %0d err %0d last %0b",
						got.kind, got.sample, got.ch, got.err, m_tlast);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parser();
			regs.chans = CHANNELS_RST;
			regs.rate = RATE_RST;
			regs.gain = GAIN_RST;
			awaited.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CHANNELS: regs.chans = cfg_data[1:0];
					REG_RATE:     regs.rate = cfg_data;
					REG_GAIN:     regs.gain = cfg_data[16:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_byte(s_tuser[0], s_tdata);
		end
		outstanding = awaited.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import wpsfe_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 30;
	localparam int LONG_HOLD     = 300;
	// random file shapes: one per header error, then a clean file, then one with a LIST chunk
	localparam int SCN_PLAIN = ERR_DEPTH + 1;
	localparam int SCN_LIST  = ERR_DEPTH + 2;
	localparam int SCN_COUNT = ERR_DEPTH + 3;

	typedef struct {
		logic [31:0] riff;
		logic [31:0] wave;
		logic [31:0] fmt_tag;
		logic [31:0] fmt_len;
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [15:0] depth;
		logic [31:0] tag;
		logic [31:0] size;
		int          list_len;
	} wav_fields_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int mismatches;
	int outstanding;
	int results_seen;

	int idle_pct;
	int stall_pct;
	bit hold_req;
	int cycles;
	int item_count;
	int files_sent;
	int settings_count;
	int scn_next;

	logic [1:0]  cur_chans;
	logic [31:0] cur_rate;
	logic [7:0]  wav_bytes [$];

	wav_pcm_stream_front_end uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wav_front_checker stream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls, or a long hold-off when requested
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_item(input logic k, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		item_count++;
	endtask

	task automatic send_file();
		send_item(1'b1, 8'($urandom));
		foreach (wav_bytes[i])
			send_item(1'b0, wav_bytes[i]);
		files_sent++;
	endtask

	// hold the sender until every pending result is out, then let the parser go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] chans, input logic [31:0] rate,
			input logic [16:0] gain);
		cfg_valid <= 1'b1;
		cfg_index <= REG_CHANNELS;
		cfg_data <= {30'd0, chans};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_RATE;
		cfg_data <= rate;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_GAIN;
		cfg_data <= {15'd0, gain};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_chans = chans;
		cur_rate = rate;
		settings_count++;
	endtask

	function automatic void add_half(logic [15:0] h);
		wav_bytes.push_back(h[7:0]);
		wav_bytes.push_back(h[15:8]);
	endfunction

	function automatic void add_word(logic [31:0] w);
		add_half(w[15:0]);
		add_half(w[31:16]);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic wav_fields_t clean_fields(logic [31:0] size);
		wav_fields_t f;
		f.riff = W_RIFF;
		f.wave = W_WAVE;
		f.fmt_tag = W_FMT;
		f.fmt_tag[31:24] = 8'($urandom);
		f.fmt_len = W_FSIZE;
		f.fmt_code = W_PCM[15:0];
		f.chans = {14'd0, cur_chans};
		f.rate = cur_rate;
		f.depth = W_DEPTH[31:16];
		f.tag = W_DATA;
		f.size = size;
		f.list_len = -1;
		return f;
	endfunction

	// flip one bit of the field that the given check looks at
	function automatic wav_fields_t corrupt(wav_fields_t f, logic [3:0] code);
		case (code)
			ERR_NOT_RIFF: f.riff ^= 32'd1 << $urandom_range(0, 31);
			ERR_NOT_WAVE: f.wave ^= 32'd1 << $urandom_range(0, 31);
			ERR_NO_FMT:   f.fmt_tag ^= 32'd1 << $urandom_range(0, 23);
			ERR_NO_DATA:  f.tag ^= 32'd1 << $urandom_range(0, 31);
			ERR_NOT_PCM:  f.fmt_code ^= 16'd1 << $urandom_range(0, 15);
			ERR_FMT_SIZE: f.fmt_len ^= 32'd1 << $urandom_range(0, 31);
			ERR_CHANNELS: f.chans ^= 16'd1 << $urandom_range(0, 15);
			ERR_RATE:     f.rate ^= 32'd1 << $urandom_range(0, 31);
			ERR_DEPTH:    f.depth ^= 16'd1 << $urandom_range(0, 15);
			default: ;
		endcase
		return f;
	endfunction

	task automatic build_wav(input wav_fields_t f, input int payload_len);
		logic [15:0] s;
		wav_bytes.delete();
		add_word(f.riff);
		add_word($urandom);
		add_word(f.wave);
		add_word(f.fmt_tag);
		add_word(f.fmt_len);
		add_half(f.fmt_code);
		add_half(f.chans);
		add_word(f.rate);
		add_word($urandom);
		add_half(16'($urandom));
		add_half(f.depth);
		if (f.list_len >= 0) begin
			add_word(W_LIST);
			add_word(f.list_len);
			repeat (f.list_len) wav_bytes.push_back(8'($urandom));
		end
		add_word(f.tag);
		add_word(f.size);
		s = '0;
		for (int i = 0; i < payload_len; i++) begin
			if (i % 2 == 0)
				s = pick_sample();
			wav_bytes.push_back((i % 2 == 0) ? s[7:0] : s[15:8]);
		end
	endtask

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return RATE_RST;
			3: return 32'd48000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 17'd0;
			1: return GAIN_RST;
			2: return 17'd65535;
			3: return 17'h1FFFF;
			4: return 17'd1;
			default: return 17'($urandom);
		endcase
	endfunction

	task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold,
			input bit mid_pause);
		int          start;
		int          scenario;
		int          payload;
		int          cut;
		logic [31:0] size;
		logic [3:0]  code;
		wav_fields_t f;
		configure(2'($urandom_range(1, 2)), pick_rate(), pick_gain());
		idle_pct = send_pct;
		stall_pct = recv_pct;
		if (long_hold)
			hold_req = 1'b1;
		start = item_count;
		while (item_count - start < PHASE_ITEMS) begin
			scenario = scn_next % SCN_COUNT;
			scn_next++;
			if ($urandom_range(0, 9) == 0) begin
				// data size too large to finish; the next file start cuts it off
				size = 32'h8000_0000 | $urandom;
				payload = $urandom_range(4, 24);
			end else begin
				size = $urandom_range(0, 20);
				payload = size + $urandom_range(0, 3);
			end
			f = clean_fields(size);
			if (scenario < SCN_PLAIN) begin
				code = 4'(scenario);
				f = corrupt(f, code);
			end else if (scenario == SCN_LIST)
				f.list_len = $urandom_range(0, 6);
			build_wav(f, payload);
			if ($urandom_range(0, 7) == 0) begin
				cut = $urandom_range(1, wav_bytes.size());
				while (wav_bytes.size() > cut)
					void'(wav_bytes.pop_back());
			end
			send_file();
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom));
			if (mid_pause && files_sent % 3 == 0)
				settle();
		end
		settle();
	endtask

	initial begin
		wav_fields_t f;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CHANNELS;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		item_count = 0;
		files_sent = 0;
		settings_count = 0;
		scn_next = $urandom_range(0, SCN_COUNT - 1);
		cur_chans = CHANNELS_RST;
		cur_rate = RATE_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stereo at reset defaults: sample extremes, odd data size, bytes after the end
		f = clean_fields(32'd11);
		build_wav(f, 0);
		add_half(16'h8000);
		add_half(16'h7FFF);
		add_half(16'h0000);
		add_half(16'hFFFF);
		add_half(16'h0001);
		wav_bytes.push_back(8'hA5);
		wav_bytes.push_back(8'hFF);
		wav_bytes.push_back(8'h00);
		send_file();
		// empty data chunk
		build_wav(clean_fields(32'd0), 0);
		send_file();
		// LIST chunk skipped before the data tag
		f = clean_fields(32'd4);
		f.list_len = 3;
		build_wav(f, 4);
		send_file();
		settle();

		// mono, rate zero, gain above unity so samples saturate
		configure(2'd1, 32'd0, 17'h1FFFF);
		build_wav(clean_fields(32'd8), 0);
		add_half(16'h8000);
		add_half(16'h7FFF);
		add_half(16'h4000);
		add_half(16'hC000);
		send_file();
		settle();
		// channel register outside mono/stereo rejects every file
		configure(2'd0, 32'hFFFF_FFFF, 17'd0);
		build_wav(clean_fields(32'd4), 4);
		send_file();
		settle();

		run_phase(0, 0, 1'b0, 1'b0);
		run_phase(59, 0, 1'b0, 1'b1);
		run_phase(0, 59, 1'b1, 1'b0);
		run_phase(17, 17, 1'b0, 1'b0);

		$display("Run covered %0d bytes in %0d files under %0d register settings,",
			item_count, files_sent, settings_count);
		$display("with %0d results checked through idle, stall and hold-off patterns.",
			results_seen);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
